// ===== rtl/core/rmof_pkg.sv =====
// Shared constants and types for the relay on-time supervisor.
package rmof_pkg;

    localparam int NUM_CHANNELS       = 9;
    localparam int EXCLUSIVE_CHANNELS = 7;

    localparam int VALVE_END = 3;
    localparam int DOSER_END = 7;
    localparam int MS_PER_S  = 1000;

    localparam int LIM_W = 16;
    localparam int MS_W  = 26;
    localparam int CH_W  = 4;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIM_W-1:0] VALVE_LIMIT_RST = 16'd600;
    localparam logic [LIM_W-1:0] DOSER_LIMIT_RST = 16'd120;
    localparam logic [LIM_W-1:0] PUMP_LIMIT_RST  = 16'd0;

    localparam logic [CFG_IDX_W-1:0] REG_VALVE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOSER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_LIMIT  = 2'd2;

    localparam logic [1:0] EV_CMD  = 2'd0;
    localparam logic [1:0] EV_PRE  = 2'd1;
    localparam logic [1:0] EV_FAIL = 2'd2;
    localparam logic [1:0] EV_SCAN = 2'd3;

    typedef struct packed {
        logic            zero;
        logic [MS_W-1:0] ms;
    } t_limit;

endpackage

// ===== rtl/core/rmof_dl_mem.sv =====
// Deadline memory: one write port, one read port with registered read data.
module rmof_dl_mem #(
    parameter int DEPTH = rmof_pkg::NUM_CHANNELS,
    parameter int AW    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [rmof_pkg::TIME_W-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [rmof_pkg::TIME_W-1:0]   o_rdata
);

    logic [rmof_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [rmof_pkg::TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rmof_cfg.sv =====
// Limit registers and the registered millisecond span for the addressed channel.
module rmof_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [rmof_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rmof_pkg::LIM_W-1:0]       i_cfg_data,
    input  logic [rmof_pkg::CH_W-1:0]        i_ch,
    output rmof_pkg::t_limit                 o_limit
);

    logic [rmof_pkg::LIM_W-1:0] r_valve;
    logic [rmof_pkg::LIM_W-1:0] r_doser;
    logic [rmof_pkg::LIM_W-1:0] r_pump;
    logic [rmof_pkg::LIM_W-1:0] lim;
    rmof_pkg::t_limit           r_limit;
    rmof_pkg::t_limit           n_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve <= rmof_pkg::VALVE_LIMIT_RST;
            r_doser <= rmof_pkg::DOSER_LIMIT_RST;
            r_pump  <= rmof_pkg::PUMP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rmof_pkg::REG_VALVE_LIMIT: r_valve <= i_cfg_data;
                rmof_pkg::REG_DOSER_LIMIT: r_doser <= i_cfg_data;
                rmof_pkg::REG_PUMP_LIMIT:  r_pump  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (5'(i_ch) < 5'(rmof_pkg::VALVE_END)) begin
            lim = r_valve;
        end else if (5'(i_ch) < 5'(rmof_pkg::DOSER_END)) begin
            lim = r_doser;
        end else begin
            lim = r_pump;
        end
        n_limit.zero = (lim == '0);
        n_limit.ms   = rmof_pkg::MS_W'(lim) * rmof_pkg::MS_W'(rmof_pkg::MS_PER_S);
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
    end

    assign o_limit = r_limit;

endmodule

// ===== rtl/core/rmof_seq.sv =====
// Command and scan sequencer with relay state, armed bits and the deadline memory.
module rmof_seq #(
    parameter int NUM_CHANNELS       = rmof_pkg::NUM_CHANNELS,
    parameter int EXCLUSIVE_CHANNELS = rmof_pkg::EXCLUSIVE_CHANNELS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [rmof_pkg::CH_W-1:0]      i_channel,
    input  logic                           i_turn_on,
    input  logic [rmof_pkg::TIME_W-1:0]    i_now_ms,
    output logic [rmof_pkg::CH_W-1:0]      o_ch,
    input  rmof_pkg::t_limit               i_limit,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_event_kind,
    output logic [rmof_pkg::CH_W-1:0]      o_report_channel,
    output logic [8:0]                     o_relay_mask,
    output logic                           o_last
);

    localparam int CW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int GRP = (EXCLUSIVE_CHANNELS < NUM_CHANNELS) ? EXCLUSIVE_CHANNELS
                                                             : NUM_CHANNELS;
    localparam logic [NUM_CHANNELS-1:0] GRP_MASK =
        NUM_CHANNELS'((64'd1 << GRP) - 64'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMD  = 3'd1;
    localparam logic [2:0] ST_PRE  = 3'd2;
    localparam logic [2:0] ST_ARM  = 3'd3;
    localparam logic [2:0] ST_SRD  = 3'd4;
    localparam logic [2:0] ST_SEV  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic [rmof_pkg::CH_W-1:0]    r_ch, n_ch;
    logic                         r_on, n_on;
    logic [rmof_pkg::TIME_W-1:0]  r_now, n_now;
    logic [CW-1:0]                r_i, n_i;
    logic [NUM_CHANNELS-1:0]      r_relay, n_relay;
    logic [NUM_CHANNELS-1:0]      r_armed, n_armed;

    logic                         r_out_valid, n_out_valid;
    logic [1:0]                   r_out_kind, n_out_kind;
    logic [rmof_pkg::CH_W-1:0]    r_out_ch, n_out_ch;
    logic [8:0]                   r_out_mask, n_out_mask;
    logic                         r_out_last, n_out_last;

    logic                         out_free;
    logic                         emit;
    logic [1:0]                   e_kind;
    logic [rmof_pkg::CH_W-1:0]    e_ch;
    logic                         e_last;
    logic [CW-1:0]                idx;
    logic                         mem_we;
    logic                         mem_re;
    logic [rmof_pkg::TIME_W-1:0]  mem_wdata;
    logic [rmof_pkg::TIME_W-1:0]  mem_rdata;
    logic [rmof_pkg::TIME_W-1:0]  sum;
    logic [rmof_pkg::TIME_W-1:0]  diff;
    logic                         in_acc;

    rmof_dl_mem #(
        .DEPTH (NUM_CHANNELS),
        .AW    (CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_i),
        .o_rdata (mem_rdata)
    );

    assign idx      = CW'(r_ch);
    assign out_free = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign sum      = r_now + rmof_pkg::TIME_W'(i_limit.ms);
    assign mem_wdata = (sum == '0) ? rmof_pkg::TIME_W'(1) : sum;
    assign diff     = r_now - mem_rdata;

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_on    = r_on;
        n_now   = r_now;
        n_i     = r_i;
        n_relay = r_relay;
        n_armed = r_armed;
        emit    = 1'b0;
        e_kind  = rmof_pkg::EV_CMD;
        e_ch    = r_ch;
        e_last  = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ch    = i_channel;
                    n_on    = i_turn_on;
                    n_now   = i_now_ms;
                    n_i     = '0;
                    n_state = i_req_type ? ST_SRD : ST_CMD;
                end
            end
            ST_CMD: begin
                if (6'(r_ch) >= 6'(NUM_CHANNELS)) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_last  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (!r_on) begin
                    if (out_free) begin
                        n_relay[idx] = 1'b0;
                        n_armed[idx] = 1'b0;
                        emit    = 1'b1;
                        e_last  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (6'(r_ch) < 6'(GRP)) begin
                    n_i     = '0;
                    n_state = ST_PRE;
                end else begin
                    n_state = ST_ARM;
                end
            end
            ST_PRE: begin
                if ((r_i != idx) && r_relay[r_i]) begin
                    if (out_free) begin
                        n_relay[r_i] = 1'b0;
                        n_armed[r_i] = 1'b0;
                        emit   = 1'b1;
                        e_kind = rmof_pkg::EV_PRE;
                        e_ch   = rmof_pkg::CH_W'(r_i);
                        if (r_i == CW'(GRP - 1)) begin
                            n_state = ST_ARM;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                end else begin
                    if (r_i != idx) begin
                        n_armed[r_i] = 1'b0;
                    end
                    if (r_i == CW'(GRP - 1)) begin
                        n_state = ST_ARM;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            ST_ARM: begin
                if (out_free) begin
                    n_relay[idx] = 1'b1;
                    n_armed[idx] = !i_limit.zero;
                    mem_we  = !i_limit.zero;
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SRD: begin
                mem_re  = 1'b1;
                n_state = ST_SEV;
            end
            ST_SEV: begin
                if (r_armed[r_i] && !diff[rmof_pkg::TIME_W-1]) begin
                    if (out_free) begin
                        n_relay[r_i] = 1'b0;
                        n_armed[r_i] = 1'b0;
                        emit   = 1'b1;
                        e_kind = rmof_pkg::EV_FAIL;
                        e_ch   = rmof_pkg::CH_W'(r_i);
                        n_state = (r_i == CW'(NUM_CHANNELS - 1)) ? ST_DONE : ST_SRD;
                        n_i     = r_i + 1'b1;
                    end
                end else begin
                    n_state = (r_i == CW'(NUM_CHANNELS - 1)) ? ST_DONE : ST_SRD;
                    n_i     = r_i + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = rmof_pkg::EV_SCAN;
                    e_ch    = '0;
                    e_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_ch    = r_out_ch;
        n_out_mask  = r_out_mask;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_kind  = e_kind;
            n_out_ch    = e_ch;
            n_out_mask  = 9'(n_relay);
            n_out_last  = e_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_relay     <= '0;
            r_armed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_relay     <= n_relay;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_on       <= n_on;
        r_now      <= n_now;
        r_i        <= n_i;
        r_out_kind <= n_out_kind;
        r_out_ch   <= n_out_ch;
        r_out_mask <= n_out_mask;
        r_out_last <= n_out_last;
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_ch             = r_ch;
    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_out_kind;
    assign o_report_channel = r_out_ch;
    assign o_relay_mask     = r_out_mask;
    assign o_last           = r_out_last;

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_relay & GRP_MASK) <= 1)
        else $error("More than one channel of the exclusive group is on.");

    a_armed_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed & ~r_relay) == '0)
        else $error("A deadline is armed for a relay that is off.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("The sequencer stayed idle after an input transfer.");

    a_scan_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == rmof_pkg::EV_SCAN)) |-> r_out_last)
        else $error("A scan-done result is not marked last.");

endmodule

// ===== rtl/core/relay_max_on_failsafe_unit.sv =====
// Relay bank controller with a maximum on-time per channel.
//
// Input stream: one transfer carries a relay command or a time-check request
// (tuser). A command switches one channel; switching on a channel of the
// exclusive group first switches off and reports every other group member
// that is on, then arms the channel's deadline from its class limit if that
// limit is not zero. A time check walks all channels and reports each one
// whose deadline has been reached, then ends with a scan-done result.
// Output stream: one transfer per event, tlast on the final one of an item.
// Configuration: one write transfer sets one limit register.
// Sequence: an off command or an out-of-range channel gives its result from
// the command state; an on command to a group channel walks the exclusive
// group member by member before the arm state. A time check reads and
// compares the deadline memory channel by channel, then gives the scan-done
// result. One item is processed at a time.
// Reset clears all relays and disarms all deadlines at once.
// When the receiver stalls, the pending result is held and the sequencer
// waits; a new input is still accepted while the last result is waiting.
module relay_max_on_failsafe_unit #(
    parameter int NUM_CHANNELS       = rmof_pkg::NUM_CHANNELS,
    parameter int EXCLUSIVE_CHANNELS = rmof_pkg::EXCLUSIVE_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // channel[3:0], turn_on[4], now_ms[36:5], zero[39:37]
    input  logic        i_s_axis_tuser,  // req_type[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // report_channel[3:0], relay_mask[12:4], zero[15:13]
    output logic [1:0]  o_m_axis_tuser,  // event_kind[1:0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [rmof_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rmof_pkg::LIM_W-1:0]     i_cfg_data
);

    rmof_pkg::t_limit              limit;
    logic [rmof_pkg::CH_W-1:0]     cur_ch;
    logic [rmof_pkg::CH_W-1:0]     out_ch;
    logic [8:0]                    out_mask;

    rmof_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ch        (cur_ch),
        .o_limit     (limit)
    );

    rmof_seq #(
        .NUM_CHANNELS       (NUM_CHANNELS),
        .EXCLUSIVE_CHANNELS (EXCLUSIVE_CHANNELS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_s_axis_tvalid),
        .o_in_ready       (o_s_axis_tready),
        .i_req_type       (i_s_axis_tuser),
        .i_channel        (i_s_axis_tdata[3:0]),
        .i_turn_on        (i_s_axis_tdata[4]),
        .i_now_ms         (i_s_axis_tdata[36:5]),
        .o_ch             (cur_ch),
        .i_limit          (limit),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_event_kind     (o_m_axis_tuser),
        .o_report_channel (out_ch),
        .o_relay_mask     (out_mask),
        .o_last           (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, out_mask, out_ch};
    assign o_cfg_ready    = 1'b1;

endmodule
